[hw/rtl/psu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;

  localparam int CAPACITY    = 1024;
  localparam int SINE_DEPTH  = 1024;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int LIVE_W      = $clog2(CAPACITY + 1);
  localparam int SINE_BITS   = $clog2(SINE_DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURBULENCE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP    = 3'd6;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [31:0] LIFE_Q16  = 32'd131072;
  localparam logic [15:0] UNIT_Q15  = 16'h8000;

  typedef struct packed {
    logic        mode;
    logic [15:0] dt;
    logic [9:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [10:0]        alive_count;
    logic               slot_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        particle_size;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
  } result_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        age;
    logic [63:0]        look;
    logic [15:0]        scale;
  } particle_t;

  localparam particle_t SPAWN_PARTICLE = '{
    px: 32'sd0, py: 32'sd0, pz: 32'sd0,
    vx: 32'sd0, vy: 32'sd327680, vz: 32'sd0,
    age: 32'd0,
    look: {UNIT_Q15, UNIT_Q15, UNIT_Q15, UNIT_Q15},
    scale: UNIT_Q15
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_SETUP, ST_EMIT, ST_WALK, ST_LOAD,
    ST_DRAG_X, ST_DRAG_Y, ST_DRAG_Z, ST_SHRINK, ST_PH_X, ST_PH_Z,
    ST_TURB, ST_POS_X, ST_POS_Y, ST_POS_Z, ST_STORE
  } state_t;

  typedef logic signed [16:0] sine_t;
  typedef sine_t sine_lut_t [SINE_DEPTH];

  // Taylor series on a folded quarter wave, Q30 internally, Q1.15 out
  function automatic sine_lut_t build_sine();
    sine_lut_t   tab;
    longint unsigned f;
    longint      g;
    longint      x;
    longint      x2;
    longint      t;
    longint      s;
    longint      q;
    logic        neg;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f   = (longint'(k) << 32) / SINE_DEPTH;
      neg = (f >= 64'h8000_0000);
      g   = longint'(f & 64'h7FFF_FFFF);
      if (g > 64'sd1073741824) g = 64'sd2147483648 - g;
      x   = (g * 64'sd1686629713) >>> 30;
      x2  = (x * x) >>> 30;
      t   = 64'sd1073741824 - x2 / 72;
      t   = 64'sd1073741824 - ((x2 * t) >>> 30) / 42;
      t   = 64'sd1073741824 - ((x2 * t) >>> 30) / 20;
      t   = 64'sd1073741824 - ((x2 * t) >>> 30) / 6;
      s   = (x * t) >>> 30;
      q   = (s + 64'sd16384) >>> 15;
      tab[k] = neg ? 17'(-q) : 17'(q);
    end
    return tab;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

  function automatic logic signed [31:0] sat32(input logic signed [54:0] v);
    if (v > 55'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -55'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/particle_system_update_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Read word: done strobes after ST_READ; a stopped tick, in the cycle after the start cycle.
// Tick while running: setup, emission, then per surviving particle a memory read, load,
// ten steps on the shared multiplier and a write back; a dying particle only reads and loads.
// busy is high for the whole item, so throughput is one item at a time.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (synchronous) clears state, live count, time, spawn accumulator, config; not memory.
module particle_system_update_step_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  psu_pkg::cmd_t                      cmd,
  output logic                               done,
  output psu_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import psu_pkg::*;

  // configuration
  logic              running, gravity_on, drag_on, fade_on, shrink_on, turbulence_on;
  logic [LIVE_W-1:0] max_capacity;
  logic [LIVE_W-1:0] cap;

  // sequencer state
  state_t            state, state_next;
  logic [LIVE_W-1:0] live;
  logic [LIVE_W-1:0] idx;
  logic [ADDR_W-1:0] src;
  logic [31:0]       elapsed;
  logic [15:0]       spawn_acc;
  logic [15:0]       emit_cnt;
  logic [15:0]       dt_q;
  logic [9:0]        slot_q;
  logic [19:0]       grav;
  logic [16:0]       drag_f;
  logic [31:0]       tphase;
  logic [31:0]       ph;
  logic [31:0]       ph_sum;
  sine_t             sine_q;
  particle_t         wk;
  particle_t         load_wk;
  result_t           idle_word, read_word;

  // particle memory: one write, one read port, registered read
  particle_t         mem [CAPACITY];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  particle_t         mem_wdata, mem_rdata;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [54:0] prod;
  logic signed [54:0] rnd16, rnd15;
  logic [54:0]        shrink_sum;

  logic [31:0]        age_new;
  logic [31:0]        acc_sum;
  logic [15:0]        fade_rg, fade_al;
  logic               emit_go;

  assign busy    = (state != ST_IDLE);
  assign cap     = (max_capacity > LIVE_W'(CAPACITY)) ? LIVE_W'(CAPACITY) : max_capacity;
  assign emit_go = (emit_cnt != 16'd0) && (live < cap);
  assign acc_sum = {16'd0, spawn_acc} + 32'(cmd.dt) * 32'd100;
  assign age_new = mem_rdata.age + 32'(dt_q);
  assign fade_rg = 16'(17'(UNIT_Q15) - 17'(age_new >> 3));
  assign fade_al = 16'(17'(UNIT_Q15) - 17'(age_new >> 2));

  assign prod       = 55'(mul_a) * 55'(mul_b);
  assign rnd16      = (prod + 55'sd32768) >>> 16;
  assign rnd15      = (prod + 55'sd16384) >>> 15;
  assign shrink_sum = $unsigned(prod) + 55'd65536;
  // turbulence phase in turns: x and z terms plus the per-tick time term
  assign ph_sum     = ph + prod[31:0] + tphase;

  // result words and the loaded particle with the first effects applied
  always_comb begin
    idle_word = '0;
    idle_word.alive_count = live;
    read_word = idle_word;
    if (LIVE_W'(slot_q) < live) begin
      read_word.slot_valid    = 1'b1;
      read_word.pos_x         = mem_rdata.px;
      read_word.pos_y         = mem_rdata.py;
      read_word.pos_z         = mem_rdata.pz;
      read_word.particle_size = mem_rdata.scale;
      read_word.red           = mem_rdata.look[15:0];
      read_word.green         = mem_rdata.look[31:16];
      read_word.blue          = mem_rdata.look[47:32];
      read_word.alpha         = mem_rdata.look[63:48];
    end
    load_wk     = mem_rdata;
    load_wk.age = age_new;
    if (gravity_on)
      load_wk.vy = sat32(55'(mem_rdata.vy) - $signed(55'(grav)));
    if (fade_on)
      load_wk.look = {fade_al, UNIT_Q15, fade_rg, fade_rg};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      gravity_on    <= 1'b0;
      drag_on       <= 1'b0;
      fade_on       <= 1'b0;
      shrink_on     <= 1'b0;
      turbulence_on <= 1'b0;
      max_capacity  <= LIVE_W'(CAPACITY);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RUNNING:    running       <= cfg_wdata[0];
        REG_GRAVITY:    gravity_on    <= cfg_wdata[0];
        REG_DRAG:       drag_on       <= cfg_wdata[0];
        REG_FADE:       fade_on       <= cfg_wdata[0];
        REG_SHRINK:     shrink_on     <= cfg_wdata[0];
        REG_TURBULENCE: turbulence_on <= cfg_wdata[0];
        REG_MAX_CAP:    max_capacity  <= cfg_wdata;
        default: ;  // unused index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state, memory control and multiplier operands
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = src;
    mem_we     = 1'b0;
    mem_waddr  = idx[ADDR_W-1:0];
    mem_wdata  = wk;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.mode == MODE_READ) begin
            mem_re     = 1'b1;
            mem_raddr  = ADDR_W'(cmd.slot);
            state_next = ST_READ;
          end else if (running) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SETUP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          mem_we    = 1'b1;
          mem_waddr = live[ADDR_W-1:0];
          mem_wdata = SPAWN_PARTICLE;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx < live) begin
          mem_re     = 1'b1;
          state_next = ST_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: state_next = (age_new >= LIFE_Q16) ? ST_WALK : ST_DRAG_X;
      ST_DRAG_X: begin
        mul_a = 33'(wk.vx);
        mul_b = $signed(22'(drag_f));
        state_next = ST_DRAG_Y;
      end
      ST_DRAG_Y: begin
        mul_a = 33'(wk.vy);
        mul_b = $signed(22'(drag_f));
        state_next = ST_DRAG_Z;
      end
      ST_DRAG_Z: begin
        mul_a = 33'(wk.vz);
        mul_b = $signed(22'(drag_f));
        state_next = ST_SHRINK;
      end
      ST_SHRINK: begin
        mul_a = $signed(33'(wk.age >> 1));
        mul_b = 22'sd58982;
        state_next = ST_PH_X;
      end
      ST_PH_X: begin
        mul_a = 33'(wk.px);
        mul_b = 22'sd135489;
        state_next = ST_PH_Z;
      end
      ST_PH_Z: begin
        mul_a = 33'(wk.pz);
        mul_b = 22'sd816000;
        state_next = ST_TURB;
      end
      ST_TURB: begin
        mul_a = 33'(sine_q);
        mul_b = $signed(22'(dt_q));
        state_next = ST_POS_X;
      end
      ST_POS_X: begin
        mul_a = 33'(wk.vx);
        mul_b = $signed(22'(dt_q));
        state_next = ST_POS_Y;
      end
      ST_POS_Y: begin
        mul_a = 33'(wk.vy);
        mul_b = $signed(22'(dt_q));
        state_next = ST_POS_Z;
      end
      ST_POS_Z: begin
        mul_a = 33'(wk.vz);
        mul_b = $signed(22'(dt_q));
        state_next = ST_STORE;
      end
      ST_STORE: begin
        mem_we     = 1'b1;
        state_next = ST_WALK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control counters and time
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      live      <= '0;
      elapsed   <= '0;
      spawn_acc <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (cmd.mode == MODE_TICK) begin
              if (running) begin
                // advance time, keep the fractional part of the accumulator
                elapsed   <= elapsed + 32'(cmd.dt);
                spawn_acc <= acc_sum[15:0];
              end else begin
                done <= 1'b1;
              end
            end
          end
        end
        ST_READ: done <= 1'b1;
        ST_EMIT: if (emit_go) live <= live + 1'b1;
        ST_WALK: if (!(idx < live)) done <= 1'b1;
        ST_LOAD: if (age_new >= LIFE_Q16) live <= live - 1'b1;
        default: ;
      endcase
    end
  end

  // datapath and result word
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          dt_q     <= cmd.dt;
          slot_q   <= cmd.slot;
          emit_cnt <= acc_sum[31:16];
          result   <= idle_word;
        end
      end
      ST_READ: result <= read_word;
      ST_SETUP: begin
        // per-tick factors, shared by every particle
        grav   <= 20'((37'(dt_q) * 37'd642253 + 37'd32768) >> 16);
        drag_f <= 17'(17'd65536 - 17'((30'(dt_q) * 30'd6554 + 30'd32768) >> 16));
        tphase <= 32'(elapsed * 32'd10430);
        idx    <= '0;
        src    <= '0;
      end
      ST_EMIT: if (emit_go) emit_cnt <= emit_cnt - 16'd1;
      ST_WALK: if (!(idx < live)) result <= idle_word;
      ST_LOAD: begin
        if (age_new >= LIFE_Q16) begin
          // dead: process the last live particle in this slot next
          src <= ADDR_W'(live - 1'b1);
        end else begin
          wk <= load_wk;
        end
      end
      ST_DRAG_X: if (drag_on) wk.vx <= sat32(rnd16);
      ST_DRAG_Y: if (drag_on) wk.vy <= sat32(rnd16);
      ST_DRAG_Z: if (drag_on) wk.vz <= sat32(rnd16);
      ST_SHRINK: if (shrink_on)
        wk.scale <= 16'(32'(UNIT_Q15) - 32'(shrink_sum >> 17));
      ST_PH_X: ph <= prod[31:0];
      // registered sine table read, one entry per particle
      ST_PH_Z: sine_q <= SINE_LUT[ph_sum[31 -: SINE_BITS]];
      ST_TURB: begin
        if (turbulence_on) begin
          wk.vx <= sat32(55'(wk.vx) + rnd15);
          wk.vz <= sat32(55'(wk.vz) + rnd15);
        end
      end
      ST_POS_X: wk.px <= sat32(55'(wk.px) + rnd16);
      ST_POS_Y: wk.py <= sat32(55'(wk.py) + rnd16);
      ST_POS_Z: wk.pz <= sat32(55'(wk.pz) + rnd16);
      ST_STORE: begin
        idx <= idx + 1'b1;
        src <= ADDR_W'(idx + 1'b1);
      end
      default: ;
    endcase
  end

  a_live_cap: assert property (@(posedge clk) disable iff (rst)
    live <= LIVE_W'(CAPACITY)) else $error("live count above capacity");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && mem_we) |=> live <= cap || $past(live) >= cap)
    else $error("emission past capacity");

  a_store_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> idx < live) else $error("write back outside live range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE) else $error("result while busy");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> !done || $past(cmd.mode) == MODE_TICK)
    else $error("read result too early");

endmodule
`default_nettype wire

[dv/tb_particle_system_update_step_unit.sv]
`timescale 1ns / 1ps
module tb_particle_system_update_step_unit;
  import psu_pkg::*;

  localparam int  NPART      = 1024;
  localparam int  RAND_WORDS = 524;
  localparam longint CYCLE_LIMIT = 8_000_000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  cmd_t                  cmd;
  logic                  done;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  particle_system_update_step_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the particle store and the block's registers.
  logic signed [31:0] p_px [NPART];
  logic signed [31:0] p_py [NPART];
  logic signed [31:0] p_pz [NPART];
  logic signed [31:0] p_vx [NPART];
  logic signed [31:0] p_vy [NPART];
  logic signed [31:0] p_vz [NPART];
  logic [31:0]        p_age [NPART];
  logic [15:0]        p_red [NPART];
  logic [15:0]        p_green [NPART];
  logic [15:0]        p_blue [NPART];
  logic [15:0]        p_alpha [NPART];
  logic [15:0]        p_size [NPART];
  int unsigned        live;
  logic [31:0]        clock_q16;
  logic [31:0]        spawn_acc;
  logic               en_run, en_grav, en_drag, en_fade, en_shrink, en_turb;
  int unsigned        cap_reg;
  longint             sine_q15 [1024];

  result_t     expected_words [$];
  int unsigned mismatches;
  int unsigned ticks_sent, reads_sent, live_reads, peak_live;
  longint      cycles;
  int unsigned burst_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: fail the run if it never drains.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sine table: folded quarter wave, Taylor series in Q30, Q1.15 out.
  function automatic longint sine_at(int k);
    longint frac, g, x, x2, t, s, q;
    frac = longint'(k) << 22;
    g = frac & 64'h7FFF_FFFF;
    if (g > 64'sd1073741824) g = 64'sd2147483648 - g;
    x  = (g * 64'sd1686629713) >>> 30;
    x2 = (x * x) >>> 30;
    t  = 64'sd1073741824 - x2 / 72;
    t  = 64'sd1073741824 - ((x2 * t) >>> 30) / 42;
    t  = 64'sd1073741824 - ((x2 * t) >>> 30) / 20;
    t  = 64'sd1073741824 - ((x2 * t) >>> 30) / 6;
    s  = (x * t) >>> 30;
    q  = (s + 64'sd16384) >>> 15;
    return (frac >= 64'h8000_0000) ? -q : q;
  endfunction

  // Round to nearest, halves toward plus infinity.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void copy_particle(int unsigned to, int unsigned from);
    p_px[to] = p_px[from];   p_py[to] = p_py[from];   p_pz[to] = p_pz[from];
    p_vx[to] = p_vx[from];   p_vy[to] = p_vy[from];   p_vz[to] = p_vz[from];
    p_age[to] = p_age[from]; p_size[to] = p_size[from];
    p_red[to] = p_red[from]; p_green[to] = p_green[from];
    p_blue[to] = p_blue[from]; p_alpha[to] = p_alpha[from];
  endfunction

  // Apply the enabled effects in fixed order, then the Euler step.
  function automatic void integrate(int unsigned k, longint dt);
    longint vx, vy, vz, f, n;
    logic [31:0] ph;
    logic [31:0] a;
    vx = p_vx[k]; vy = p_vy[k]; vz = p_vz[k];
    a = p_age[k];
    if (en_grav) vy = clamp32(vy - rnd_shift(64'sd642253 * dt, 16));
    if (en_drag) begin
      f  = 64'sd65536 - rnd_shift(64'sd6554 * dt, 16);
      vx = clamp32(rnd_shift(vx * f, 16));
      vy = clamp32(rnd_shift(vy * f, 16));
      vz = clamp32(rnd_shift(vz * f, 16));
    end
    if (en_fade) begin
      p_red[k]   = UNIT_Q15 - 16'(a >> 3);
      p_green[k] = UNIT_Q15 - 16'(a >> 3);
      p_blue[k]  = UNIT_Q15;
      p_alpha[k] = UNIT_Q15 - 16'(a >> 2);
    end
    if (en_shrink)
      p_size[k] = 16'(32'd32768 - 32'((longint'(a >> 1) * 58982 + 65536) >> 17));
    if (en_turb) begin
      // phase in turns, modulo one, keeps only the low 32 bits
      ph = 32'(longint'(p_px[k]) * 135489) + 32'(longint'(p_pz[k]) * 816000) +
           clock_q16 * 32'd10430;
      n  = rnd_shift(sine_q15[ph[31:22]] * dt, 15);
      vx = clamp32(vx + n);
      vz = clamp32(vz + n);
    end
    p_vx[k] = vx; p_vy[k] = vy; p_vz[k] = vz;
    p_px[k] = clamp32(longint'(p_px[k]) + rnd_shift(vx * dt, 16));
    p_py[k] = clamp32(longint'(p_py[k]) + rnd_shift(vy * dt, 16));
    p_pz[k] = clamp32(longint'(p_pz[k]) + rnd_shift(vz * dt, 16));
  endfunction

  function automatic void advance_system(logic [15:0] dt);
    int unsigned i, whole, lim;
    logic [31:0] a;
    clock_q16 = clock_q16 + dt;
    spawn_acc = spawn_acc + 32'd100 * dt;
    if (spawn_acc >= 32'd65536) begin
      whole = spawn_acc >> 16;
      spawn_acc = spawn_acc & 32'hFFFF;
      lim = (cap_reg > NPART) ? NPART : cap_reg;
      for (int e = 0; e < whole && live < lim; e++) begin
        p_px[live] = 0; p_py[live] = 0; p_pz[live] = 0;
        p_vx[live] = 0; p_vy[live] = 32'sd327680; p_vz[live] = 0;
        p_age[live] = 0; p_size[live] = UNIT_Q15;
        p_red[live] = UNIT_Q15; p_green[live] = UNIT_Q15;
        p_blue[live] = UNIT_Q15; p_alpha[live] = UNIT_Q15;
        live++;
      end
    end
    i = 0;
    while (i < live) begin
      a = p_age[i] + dt;
      p_age[i] = a;
      if (a >= LIFE_Q16) begin
        // expired: pull the last one in and process it in this slot
        if (i < live - 1) copy_particle(i, live - 1);
        live--;
      end else begin
        integrate(i, longint'(dt));
        i++;
      end
    end
    if (live > peak_live) peak_live = live;
  endfunction

  function automatic result_t predict_word(cmd_t c);
    result_t r;
    r = '0;
    if (c.mode == MODE_TICK) begin
      if (en_run) advance_system(c.dt);
    end else if (c.slot < live) begin
      r.slot_valid    = 1'b1;
      r.pos_x         = p_px[c.slot];
      r.pos_y         = p_py[c.slot];
      r.pos_z         = p_pz[c.slot];
      r.particle_size = p_size[c.slot];
      r.red           = p_red[c.slot];
      r.green         = p_green[c.slot];
      r.blue          = p_blue[c.slot];
      r.alpha         = p_alpha[c.slot];
    end
    r.alive_count = 11'(live);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h at cycle %0d", name, want, got, cycles);
    end
  endtask

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin
    result_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        w = expected_words.pop_front();
        check_field("alive_count", w.alive_count, result.alive_count);
        check_field("slot_valid", w.slot_valid, result.slot_valid);
        check_field("pos_x", w.pos_x, result.pos_x);
        check_field("pos_y", w.pos_y, result.pos_y);
        check_field("pos_z", w.pos_z, result.pos_z);
        check_field("particle_size", w.particle_size, result.particle_size);
        check_field("red", w.red, result.red);
        check_field("green", w.green, result.green);
        check_field("blue", w.blue, result.blue);
        check_field("alpha", w.alpha, result.alpha);
      end
    end
  end

  // Send one command word; bursts of random length separated by random gaps.
  task automatic send_word(logic mode, logic [15:0] dt, logic [9:0] slot);
    cmd_t c;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    while (busy) @(negedge clk);
    c.mode = mode; c.dt = dt; c.slot = slot;
    cmd   <= c;
    start <= 1'b1;
    expected_words.insert(expected_words.size(), predict_word(c));
    if (mode == MODE_TICK) ticks_sent++;
    else begin
      reads_sent++;
      if (slot < live) live_reads++;
    end
    @(negedge clk);
    start <= 1'b0;
    cmd   <= cmd_t'($urandom);
    @(negedge clk);
  endtask

  task automatic tick(logic [15:0] dt);
    send_word(MODE_TICK, dt, 10'($urandom));
  endtask

  task automatic read_slot(logic [9:0] slot);
    send_word(MODE_READ, 16'($urandom), slot);
  endtask

  // Drain, let the block settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    while (expected_words.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    cfg_we    <= 1'b1;
    case (idx)
      REG_RUNNING:    en_run    = val[0];
      REG_GRAVITY:    en_grav   = val[0];
      REG_DRAG:       en_drag   = val[0];
      REG_FADE:       en_fade   = val[0];
      REG_SHRINK:     en_shrink = val[0];
      REG_TURBULENCE: en_turb   = val[0];
      REG_MAX_CAP:    cap_reg   = val & 11'h7FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_effects(logic [4:0] mask);
    write_reg(REG_GRAVITY, mask[0]);
    write_reg(REG_DRAG, mask[1]);
    write_reg(REG_FADE, mask[2]);
    write_reg(REG_SHRINK, mask[3]);
    write_reg(REG_TURBULENCE, mask[4]);
  endtask

  task automatic read_some_live();
    for (int k = 0; k < 3; k++)
      read_slot(live == 0 ? 10'd0 : 10'($urandom_range(0, live - 1)));
  endtask

  // Stopped block: ticks change nothing, reads of dead slots return zero.
  task automatic test_stopped();
    tick(16'hFFFF);
    read_slot(10'd0);
    read_slot(10'd1023);
  endtask

  // Spawning at the dt extremes with no effects, then death and compaction.
  task automatic test_spawn_and_expire();
    write_reg(REG_MAX_CAP, 40);
    write_reg(REG_RUNNING, 1);
    tick(16'd0);
    tick(16'd1);
    tick(16'hFFFF);
    read_slot(10'd0);
    read_slot(10'd39);
    read_slot(10'd40);
    tick(16'h8000);
    tick(16'hFFFF);
    read_some_live();
    tick(16'hFFFF);
    read_slot(10'd0);
  endtask

  // Capacity zero, one, lowered below the live count, and above the store.
  task automatic test_capacity();
    write_reg(REG_MAX_CAP, 0);
    tick(16'hFFFF);
    write_reg(REG_MAX_CAP, 1);
    tick(16'h4000);
    tick(16'h4000);
    read_slot(10'd0);
    write_reg(REG_MAX_CAP, 30);
    tick(16'h7000);
    write_reg(REG_MAX_CAP, 2);
    tick(16'h3000);
    read_slot(10'd5);
    write_reg(REG_MAX_CAP, 2047);
    tick(16'hFFFF);
    tick(16'h1000);
    read_slot(10'd100);
  endtask

  // Each effect alone, then everything together.
  task automatic test_each_effect();
    write_reg(REG_MAX_CAP, 12);
    for (int b = 0; b < 5; b++) begin
      set_effects(5'b1 << b);
      tick(16'h2000);
      tick(16'h6000);
      read_some_live();
    end
    set_effects(5'b11111);
    tick(16'h5555);
    tick(16'hAAAA);
    read_some_live();
  endtask

  // Random phases: each picks a setting, then a mix of ticks and reads.
  task automatic test_random_phases();
    int unsigned left, n;
    logic [15:0] dt;
    left = RAND_WORDS;
    while (left > 0) begin
      write_reg(REG_RUNNING, $urandom_range(0, 7) != 0);
      set_effects(5'($urandom));
      case ($urandom_range(0, 9))
        0: write_reg(REG_MAX_CAP, 1024);
        1: write_reg(REG_MAX_CAP, 2047);
        2: write_reg(REG_MAX_CAP, $urandom_range(0, 2));
        default: write_reg(REG_MAX_CAP, $urandom_range(3, 48));
      endcase
      n = $urandom_range(15, 45);
      if (n > left) n = left;
      left -= n;
      repeat (n) begin
        if ($urandom_range(0, 9) < 6) begin
          case ($urandom_range(0, 3))
            0: dt = 16'($urandom);
            1: dt = 16'($urandom_range(0, 255));
            default: dt = 16'($urandom_range(4096, 24576));
          endcase
          tick(dt);
        end else if ($urandom_range(0, 3) == 0 || live == 0) begin
          read_slot(10'($urandom));
        end else begin
          read_slot(10'($urandom_range(0, live + 2)));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cmd = '0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    cycles = 0; mismatches = 0; burst_left = 0;
    ticks_sent = 0; reads_sent = 0; live_reads = 0; peak_live = 0;
    for (int k = 0; k < 1024; k++) sine_q15[k] = sine_at(k);
    live = 0; clock_q16 = 0; spawn_acc = 0;
    en_run = 0; en_grav = 0; en_drag = 0; en_fade = 0; en_shrink = 0; en_turb = 0;
    cap_reg = 1024;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_stopped();
    test_spawn_and_expire();
    test_capacity();
    test_each_effect();
    test_random_phases();

    // hold until every word is back, then give the block time to settle
    while (expected_words.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d ticks and %0d reads (%0d of live particles)",
             ticks_sent, reads_sent, live_reads);
    $display("peak live count %0d, %0d mismatches", peak_live, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
